/* hw/rtl/dequ_pkg.sv */
// ---------------------------------------------------------------------------
// dequ_pkg: shared types and constants of the double-ended queue unit
// Field widths, operation and status codes, and the sequencer state type.
// ---------------------------------------------------------------------------
package dequ_pkg;

    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int LENGTH_W = 6;

    // Operation class, taken from the upper two bits of the mode field.
    // The low mode bit selects the tail end.
    typedef enum logic [1:0] {
        OP_PUT = 2'd0,
        OP_GET = 2'd1,
        OP_ITH = 2'd2,
        OP_REM = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_RANGE    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ZERO     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RD,
        S_SRCH,
        S_SHIFT,
        S_FIN
    } t_state;

endpackage

/* hw/rtl/dequ_chan_if.sv */
// ---------------------------------------------------------------------------
// dequ_chan_if: command and result channels of the double-ended queue unit
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ---------------------------------------------------------------------------
interface dequ_in_if;
    logic                         valid;
    logic                         ready;
    logic [dequ_pkg::MODE_W-1:0]  mode;
    logic [dequ_pkg::VALUE_W-1:0] value;
    logic [dequ_pkg::INDEX_W-1:0] index;

    modport source (output valid, output mode, output value, output index, input ready);
    modport sink   (input valid, input mode, input value, input index, output ready);
endinterface

interface dequ_out_if;
    logic                          valid;
    logic                          ready;
    logic [dequ_pkg::DATA_W-1:0]   data;
    logic [dequ_pkg::STATUS_W-1:0] status;
    logic [dequ_pkg::LENGTH_W-1:0] length;

    modport source (output valid, output data, output status, output length, input ready);
    modport sink   (input valid, input data, input status, input length, output ready);
endinterface

/* hw/rtl/double_ended_queue_unit.sv */
// ---------------------------------------------------------------------------
// double_ended_queue_unit: bounded double-ended queue on a ring store
// The unit takes one command at a time and answers each with exactly one
// result (data, status, length). Put and failing get or ith go from decode
// straight to finish; get and ith that read an entry pass a read state first.
// Removal by value searches the queue one entry per cycle through the single
// read port of the entry store and then closes the gap one entry per cycle,
// read and write overlapped. The command channel is ready only while no
// command is in work; a finished result sits in an output register, so the
// next command can be taken while that result still waits for its transfer.
// Failed operations report a status and leave the queue unchanged. Only
// entries that were written reach a result, so the store needs no clearing
// after reset.
// ---------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dequ_in_if.sink    i_cmd,
    dequ_out_if.source o_res
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > dequ_pkg::INDEX_W) ? CW : dequ_pkg::INDEX_W;

    // Sequencer state.
    dequ_pkg::t_state r_state;
    dequ_pkg::t_state n_state;

    // Queue state: head slot and entry count.
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;

    // Command held while it is in work.
    logic [dequ_pkg::MODE_W-1:0]  r_mode;
    logic [DATA_WIDTH-1:0]        r_val;
    logic [dequ_pkg::INDEX_W-1:0] r_idx;

    // Working result.
    logic [DATA_WIDTH-1:0] r_data;
    dequ_pkg::t_status     r_status;

    // Search and shift bookkeeping. r_k walks the queue; r_pend marks a read
    // in flight whose data arrives in the next cycle; r_pk and r_ps hold the
    // position and slot of that read during the search; r_tslot is the slot
    // that the next shifted word goes to, r_sslot the slot it was read from.
    logic [CW-1:0] r_k;
    logic          r_pend;
    logic [CW-1:0] r_pk;
    logic [AW-1:0] r_ps;
    logic [AW-1:0] r_tslot;
    logic [AW-1:0] r_sslot;

    // Output register.
    logic                          r_ovalid;
    logic [dequ_pkg::DATA_W-1:0]   r_odata;
    logic [dequ_pkg::STATUS_W-1:0] r_ostatus;
    logic [dequ_pkg::LENGTH_W-1:0] r_olen;

    // Decoded command and conditions.
    dequ_pkg::t_op op;
    logic          tail;
    logic          val_zero;
    logic          is_empty;
    logic          is_full;
    logic          ith_ok;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] idx_c;
    logic [CW-1:0] k_next;
    logic          hit;
    logic          srch_done;
    logic          shift_more;
    logic          out_free;
    logic [63:0]   value_ext;
    logic [63:0]   data_ext;
    logic [CMPW-1:0] idx_ext;
    logic [CMPW-1:0] cnt_ext;

    // Shared ring address unit and memory port controls.
    logic [CW-1:0]         pos;
    logic [AW-1:0]         slot;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [DATA_WIDTH-1:0] ram_rdata;

    dequ_slot #(
        .DEPTH (DEPTH)
    ) u_slot (
        .i_head (r_head),
        .i_pos  (pos),
        .o_slot (slot)
    );

    dequ_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        op         = dequ_pkg::t_op'(r_mode[2:1]);
        tail       = r_mode[0];
        val_zero   = (r_val == '0);
        is_empty   = (r_count == '0);
        is_full    = (r_count == CW'(DEPTH));
        idx_ext    = CMPW'(r_idx);
        cnt_ext    = CMPW'(r_count);
        ith_ok     = (idx_ext < cnt_ext);
        // Only used once the index is known to be below the count.
        idx_c      = CW'(idx_ext);
        cnt_m1     = r_count - CW'(1);
        k_next     = r_k + CW'(1);
        hit        = r_pend && (ram_rdata == r_val);
        srch_done  = (r_k == r_count);
        shift_more = (k_next < r_count);
        out_free   = !r_ovalid || o_res.ready;
        value_ext  = 64'(i_cmd.value);
        data_ext   = 64'(r_data);
    end

    assign i_cmd.ready  = (r_state == dequ_pkg::S_IDLE);
    assign o_res.valid  = r_ovalid;
    assign o_res.data   = r_odata;
    assign o_res.status = r_ostatus;
    assign o_res.length = r_olen;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dequ_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    n_state = dequ_pkg::S_DEC;
                end
            end
            dequ_pkg::S_DEC: begin
                unique case (op)
                    dequ_pkg::OP_PUT: n_state = dequ_pkg::S_FIN;
                    dequ_pkg::OP_GET: begin
                        n_state = is_empty ? dequ_pkg::S_FIN : dequ_pkg::S_RD;
                    end
                    dequ_pkg::OP_ITH: begin
                        n_state = (is_empty || !ith_ok) ? dequ_pkg::S_FIN : dequ_pkg::S_RD;
                    end
                    dequ_pkg::OP_REM: begin
                        n_state = (val_zero || is_empty) ? dequ_pkg::S_FIN : dequ_pkg::S_SRCH;
                    end
                    default: n_state = dequ_pkg::S_FIN;
                endcase
            end
            dequ_pkg::S_RD: n_state = dequ_pkg::S_FIN;
            dequ_pkg::S_SRCH: begin
                if (hit) begin
                    n_state = dequ_pkg::S_SHIFT;
                end else if (srch_done) begin
                    n_state = dequ_pkg::S_FIN;
                end
            end
            dequ_pkg::S_SHIFT: begin
                if (!shift_more) begin
                    n_state = dequ_pkg::S_FIN;
                end
            end
            dequ_pkg::S_FIN: begin
                if (out_free) begin
                    n_state = dequ_pkg::S_IDLE;
                end
            end
            default: n_state = dequ_pkg::S_IDLE;
        endcase
    end

    // Address unit input and memory port controls.
    always_comb begin
        pos       = r_count;
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = r_val;
        ram_re    = 1'b0;
        unique case (r_state)
            dequ_pkg::S_DEC: begin
                unique case (op)
                    dequ_pkg::OP_PUT: begin
                        // Tail push writes behind the last entry; head push
                        // writes the slot before the head.
                        pos    = tail ? r_count : CW'(DEPTH - 1);
                        ram_we = !val_zero && !is_full;
                    end
                    dequ_pkg::OP_GET: begin
                        pos    = tail ? cnt_m1 : '0;
                        ram_re = 1'b1;
                    end
                    dequ_pkg::OP_ITH: begin
                        pos    = tail ? (cnt_m1 - idx_c) : idx_c;
                        ram_re = 1'b1;
                    end
                    default: pos = r_count;
                endcase
            end
            dequ_pkg::S_RD: begin
                // Slot after the head, for a pop at the head.
                pos = CW'(1);
            end
            dequ_pkg::S_SRCH: begin
                pos    = tail ? (cnt_m1 - r_k) : r_k;
                ram_re = !hit && !srch_done;
            end
            dequ_pkg::S_SHIFT: begin
                // Read the next entry while the previous one moves down.
                pos       = k_next;
                ram_re    = shift_more;
                ram_we    = r_pend;
                ram_waddr = r_tslot;
                ram_wdata = ram_rdata;
            end
            default: pos = r_count;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dequ_pkg::S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            unique case (r_state)
                dequ_pkg::S_DEC: begin
                    r_pend <= 1'b0;
                    if (op == dequ_pkg::OP_PUT && !val_zero && !is_full) begin
                        r_count <= r_count + CW'(1);
                        if (!tail) begin
                            r_head <= slot;
                        end
                    end
                end
                dequ_pkg::S_RD: begin
                    if (op == dequ_pkg::OP_GET) begin
                        r_count <= cnt_m1;
                        if (!tail) begin
                            r_head <= slot;
                        end
                    end
                end
                dequ_pkg::S_SRCH: begin
                    if (hit) begin
                        r_pend <= 1'b0;
                    end else if (!srch_done) begin
                        r_pend <= 1'b1;
                    end
                end
                dequ_pkg::S_SHIFT: begin
                    if (shift_more) begin
                        r_pend <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                        r_count <= cnt_m1;
                    end
                end
                default: begin
                end
            endcase

            if (r_state == dequ_pkg::S_FIN && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            dequ_pkg::S_IDLE: begin
                if (i_cmd.valid) begin
                    r_mode <= i_cmd.mode;
                    r_val  <= value_ext[DATA_WIDTH-1:0];
                    r_idx  <= i_cmd.index;
                end
            end
            dequ_pkg::S_DEC: begin
                r_data   <= '0;
                r_status <= dequ_pkg::ST_OK;
                r_k      <= '0;
                unique case (op)
                    dequ_pkg::OP_PUT: begin
                        if (val_zero) begin
                            r_status <= dequ_pkg::ST_ZERO;
                        end else if (is_full) begin
                            r_status <= dequ_pkg::ST_FULL;
                        end
                    end
                    dequ_pkg::OP_GET: begin
                        if (is_empty) begin
                            r_status <= dequ_pkg::ST_EMPTY;
                        end
                    end
                    dequ_pkg::OP_ITH: begin
                        if (is_empty) begin
                            r_status <= dequ_pkg::ST_EMPTY;
                        end else if (!ith_ok) begin
                            r_status <= dequ_pkg::ST_RANGE;
                        end
                    end
                    dequ_pkg::OP_REM: begin
                        if (val_zero) begin
                            r_status <= dequ_pkg::ST_ZERO;
                        end else if (is_empty) begin
                            r_status <= dequ_pkg::ST_EMPTY;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            dequ_pkg::S_RD: begin
                r_data <= ram_rdata;
            end
            dequ_pkg::S_SRCH: begin
                if (hit) begin
                    // The matching entry becomes the first gap to close.
                    r_data  <= ram_rdata;
                    r_k     <= r_pk;
                    r_tslot <= r_ps;
                end else if (srch_done) begin
                    r_status <= dequ_pkg::ST_NOTFOUND;
                end else begin
                    r_pk <= pos;
                    r_ps <= slot;
                    r_k  <= k_next;
                end
            end
            dequ_pkg::S_SHIFT: begin
                if (r_pend) begin
                    r_tslot <= r_sslot;
                end
                if (shift_more) begin
                    r_sslot <= slot;
                    r_k     <= k_next;
                end
            end
            dequ_pkg::S_FIN: begin
                if (out_free) begin
                    r_odata   <= data_ext[dequ_pkg::DATA_W-1:0];
                    r_ostatus <= r_status;
                    r_olen    <= dequ_pkg::LENGTH_W'(r_count);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hw/rtl/dequ_ram.sv */
// ---------------------------------------------------------------------------
// dequ_ram: entry store
// Simple dual-port memory, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
module dequ_ram #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_WIDTH-1:0]    i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_WIDTH-1:0]    o_rdata
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* hw/rtl/dequ_slot.sv */
// ---------------------------------------------------------------------------
// dequ_slot: ring address unit
// Maps a position counted from the head to its slot in the ring store.
// ---------------------------------------------------------------------------
module dequ_slot #(
    parameter int DEPTH = 32
) (
    input  logic [$clog2(DEPTH)-1:0]   i_head,
    input  logic [$clog2(DEPTH+1)-1:0] i_pos,
    output logic [$clog2(DEPTH)-1:0]   o_slot
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW:0] sum;
    logic [CW:0] wrapped;

    // Head and position are both at most DEPTH, so one subtract wraps the sum.
    always_comb begin
        sum     = (CW+1)'(i_head) + (CW+1)'(i_pos);
        wrapped = sum - (CW+1)'(DEPTH);
        o_slot  = (sum >= (CW+1)'(DEPTH)) ? AW'(wrapped) : AW'(sum);
    end

endmodule
